[hdl/tpcm_pkg.sv]
package tpcm_pkg;

   localparam int PHYS_WIDTH    = 800;
   localparam int PHYS_HEIGHT   = 480;
   localparam int TARGET_WIDTH  = 800;
   localparam int TARGET_HEIGHT = 480;

   localparam int RAW_W      = 12;
   localparam int SMAX_W     = 12;
   localparam int LEFT_W     = 11;
   localparam int RIGHT_W    = 11;
   localparam int TOP_W      = 10;
   localparam int BOTTOM_W   = 10;
   localparam int SHIFT_W    = 8;
   localparam int SX_W       = 10;
   localparam int SY_W       = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int LOW_W  = (LEFT_W > TOP_W) ? LEFT_W : TOP_W;
   localparam int HIGH_W = (RIGHT_W > BOTTOM_W) ? RIGHT_W : BOTTOM_W;

   // bits of PHYS-1 and TARGET-1
   localparam int PX_W = $clog2(PHYS_WIDTH);
   localparam int PY_W = $clog2(PHYS_HEIGHT);
   localparam int PB_W = (PX_W > PY_W) ? PX_W : PY_W;
   localparam int TX_W = $clog2(TARGET_WIDTH);
   localparam int TY_W = $clog2(TARGET_HEIGHT);
   localparam int TB_W = (TX_W > TY_W) ? TX_W : TY_W;
   localparam int FB_W = (SX_W > SY_W) ? SX_W : SY_W;
   localparam int OUT_W = (TB_W > FB_W) ? TB_W : FB_W;

   // datapath widths
   localparam int N1_W   = RAW_W + PB_W;
   localparam int D1_W   = SMAX_W;
   localparam int D2_W   = HIGH_W + 1;
   localparam int SPAN_W = D2_W + 1;
   localparam int DLT_W  = N1_W + 2;
   localparam int M2_W   = N1_W + 1;
   localparam int N2_W   = M2_W + PB_W;
   localparam int SUM_W  = N2_W + 2;

   localparam int LATENCY = N1_W + N2_W + 4;

   localparam int SCREEN_X_MAX =
      (TARGET_WIDTH - 1 < 2 ** SX_W) ? TARGET_WIDTH - 1 : 2 ** SX_W - 1;
   localparam int SCREEN_Y_MAX =
      (TARGET_HEIGHT - 1 < 2 ** SY_W) ? TARGET_HEIGHT - 1 : 2 ** SY_W - 1;

   localparam logic [SMAX_W-1:0]          RST_SENSOR_MAX_X = 12'd800;
   localparam logic [SMAX_W-1:0]          RST_SENSOR_MAX_Y = 12'd480;
   localparam logic signed [LEFT_W-1:0]   RST_LEFT_EDGE    = 11'sd0;
   localparam logic [RIGHT_W-1:0]         RST_RIGHT_EDGE   = 11'd799;
   localparam logic signed [TOP_W-1:0]    RST_TOP_EDGE     = 10'sd0;
   localparam logic [BOTTOM_W-1:0]        RST_BOTTOM_EDGE  = 10'd479;
   localparam logic signed [SHIFT_W-1:0]  RST_SHIFT        = 8'sd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_MAX_X = 3'd0,
      CSR_SENSOR_MAX_Y = 3'd1,
      CSR_LEFT_EDGE    = 3'd2,
      CSR_RIGHT_EDGE   = 3'd3,
      CSR_TOP_EDGE     = 3'd4,
      CSR_BOTTOM_EDGE  = 3'd5,
      CSR_SHIFT_X      = 3'd6,
      CSR_SHIFT_Y      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SMAX_W-1:0]         smax;
      logic signed [LOW_W-1:0]   low;
      logic [HIGH_W-1:0]         high;
      logic signed [SHIFT_W-1:0] shift;
   } axis_cfg_type;

endpackage

[hdl/tpcm_if.sv]
interface tpcm_req_if import tpcm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   modport source (output valid, raw_x, raw_y, input ready);
   modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

interface tpcm_rsp_if import tpcm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [SX_W-1:0] screen_x;
   logic [SY_W-1:0] screen_y;

   modport source (output valid, screen_x, screen_y, input ready);
   modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

interface tpcm_csr_if import tpcm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tpcm_axis.sv]
module tpcm_axis import tpcm_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [RAW_W-1:0] raw,
   input  axis_cfg_type     cfg,
   input  logic [PB_W-1:0]  phys_m1,
   input  logic [OUT_W-1:0] tgt_max,
   output logic [OUT_W-1:0] result
);

   logic                     skip1;
   logic                     skip2;
   logic [D1_W-1:0]          d1;
   logic [D2_W-1:0]          d2;
   logic signed [SPAN_W-1:0] span;

   logic [N1_W-1:0] n1_in;
   logic [D1_W-1:0] rem1_ff [N1_W+1];
   logic [N1_W-1:0] nq1_ff  [N1_W+1];
   logic [D1_W:0]   t1      [N1_W];
   logic [D1_W:0]   dif1    [N1_W];
   logic            ge1     [N1_W];
   logic [D1_W-1:0] rem1_in [N1_W];
   logic [N1_W-1:0] nq1_in  [N1_W];

   logic signed [DLT_W-1:0] dlt;
   logic [DLT_W-1:0]        abs_c;
   logic                    neg_in;
   logic [M2_W-1:0]         mag_in;
   logic                    neg_b_ff;
   logic [M2_W-1:0]         mag_b_ff;

   logic [N2_W-1:0] n2_in;
   logic [D2_W-1:0] rem2_ff [N2_W+1];
   logic [N2_W-1:0] nq2_ff  [N2_W+1];
   logic            neg2_ff [N2_W+1];
   logic [D2_W:0]   t2      [N2_W];
   logic [D2_W:0]   dif2    [N2_W];
   logic            ge2     [N2_W];
   logic [D2_W-1:0] rem2_in [N2_W];
   logic [N2_W-1:0] nq2_in  [N2_W];

   logic signed [SUM_W-1:0] sq;
   logic signed [SUM_W-1:0] sum;
   logic [OUT_W-1:0]        res_in;
   logic [OUT_W-1:0]        res_ff;

   // divisors follow the registers, which the user must hold still while points are in flight; not enforced here
   always_comb begin
      skip1 = (cfg.smax <= SMAX_W'(1)) ||
              ((cfg.smax - SMAX_W'(1)) == SMAX_W'(phys_m1));
      d1    = skip1 ? SMAX_W'(1) : cfg.smax - SMAX_W'(1);
      span  = SPAN_W'($signed({1'b0, cfg.high})) - SPAN_W'(cfg.low);
      skip2 = (span <= 0);
      d2    = skip2 ? D2_W'(1) : span[D2_W-1:0];
   end

   // stage 0: sensor rescale product
   always_comb begin
      n1_in = skip1 ? N1_W'(raw) : N1_W'(raw) * N1_W'(phys_m1);
   end

   // rescale quotient, one bit per stage
   always_comb begin
      for (int k = 0; k < N1_W; k++) begin
         t1[k]      = {rem1_ff[k], nq1_ff[k][N1_W-1]};
         dif1[k]    = t1[k] - {1'b0, d1};
         ge1[k]     = (t1[k] >= {1'b0, d1});
         rem1_in[k] = ge1[k] ? dif1[k][D1_W-1:0] : t1[k][D1_W-1:0];
         nq1_in[k]  = {nq1_ff[k][N1_W-2:0], ge1[k]};
      end
   end

   // edge offset and magnitude
   always_comb begin
      dlt    = $signed(DLT_W'(nq1_ff[N1_W])) - DLT_W'(cfg.low);
      abs_c  = dlt[DLT_W-1] ? DLT_W'(-dlt) : DLT_W'(dlt);
      neg_in = !skip2 && dlt[DLT_W-1];
      mag_in = skip2 ? M2_W'(nq1_ff[N1_W]) : abs_c[M2_W-1:0];
   end

   always_comb begin
      n2_in = skip2 ? N2_W'(mag_b_ff) : N2_W'(mag_b_ff) * N2_W'(phys_m1);
   end

   // edge calibration quotient, one bit per stage
   always_comb begin
      for (int k = 0; k < N2_W; k++) begin
         t2[k]      = {rem2_ff[k], nq2_ff[k][N2_W-1]};
         dif2[k]    = t2[k] - {1'b0, d2};
         ge2[k]     = (t2[k] >= {1'b0, d2});
         rem2_in[k] = ge2[k] ? dif2[k][D2_W-1:0] : t2[k][D2_W-1:0];
         nq2_in[k]  = {nq2_ff[k][N2_W-2:0], ge2[k]};
      end
   end

   // sign back on (truncation toward zero), shift, clamp
   always_comb begin
      sq  = neg2_ff[N2_W] ? -$signed(SUM_W'(nq2_ff[N2_W]))
                          :  $signed(SUM_W'(nq2_ff[N2_W]));
      sum = sq + SUM_W'(cfg.shift);
      priority if (sum[SUM_W-1]) begin
         res_in = '0;
      end else if (sum > $signed(SUM_W'(tgt_max))) begin
         res_in = tgt_max;
      end else begin
         res_in = sum[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem1_ff[0] <= '0;
         nq1_ff[0]  <= n1_in;
         for (int k = 0; k < N1_W; k++) begin
            rem1_ff[k+1] <= rem1_in[k];
            nq1_ff[k+1]  <= nq1_in[k];
         end
         neg_b_ff   <= neg_in;
         mag_b_ff   <= mag_in;
         rem2_ff[0] <= '0;
         nq2_ff[0]  <= n2_in;
         neg2_ff[0] <= neg_b_ff;
         for (int k = 0; k < N2_W; k++) begin
            rem2_ff[k+1] <= rem2_in[k];
            nq2_ff[k+1]  <= nq2_in[k];
            neg2_ff[k+1] <= neg2_ff[k];
         end
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

[hdl/touch_point_calibration_map_core.sv]
// channel   dir  handshake      payload
// req_bus   in   valid/ready    raw_x[11:0], raw_y[11:0]
// rsp_bus   out  valid/ready    screen_x[9:0], screen_y[8:0]
// csr_bus   in   valid/ready    index[2:0], data[11:0]; ready always high
//
// One point per cycle while the result is not stalled. The two bit-per-stage
// quotient chains hold N1 = 12 + clog2(larger PHYS) stages for the rescale and
// N2 = N1 + 1 + clog2(larger PHYS) stages for the edge calibration.
// Synchronous reset clears the registers to their defaults and empties the pipe.
// A stalled result freezes every stage; req ready drops only while a result waits.
module touch_point_calibration_map_core import tpcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tpcm_req_if.sink    req_bus,
   tpcm_rsp_if.source  rsp_bus,
   tpcm_csr_if.sink    csr_bus
);

   logic [SMAX_W-1:0]         sensor_max_x_ff;
   logic [SMAX_W-1:0]         sensor_max_y_ff;
   logic signed [LEFT_W-1:0]  left_edge_ff;
   logic [RIGHT_W-1:0]        right_edge_ff;
   logic signed [TOP_W-1:0]   top_edge_ff;
   logic [BOTTOM_W-1:0]       bottom_edge_ff;
   logic signed [SHIFT_W-1:0] shift_x_ff;
   logic signed [SHIFT_W-1:0] shift_y_ff;

   logic [LATENCY-1:0] vld_ff;
   logic               adv;
   axis_cfg_type       cfg_x;
   axis_cfg_type       cfg_y;
   logic [OUT_W-1:0]   res_x;
   logic [OUT_W-1:0]   res_y;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_max_x_ff <= RST_SENSOR_MAX_X;
         sensor_max_y_ff <= RST_SENSOR_MAX_Y;
         left_edge_ff    <= RST_LEFT_EDGE;
         right_edge_ff   <= RST_RIGHT_EDGE;
         top_edge_ff     <= RST_TOP_EDGE;
         bottom_edge_ff  <= RST_BOTTOM_EDGE;
         shift_x_ff      <= RST_SHIFT;
         shift_y_ff      <= RST_SHIFT;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SENSOR_MAX_X: sensor_max_x_ff <= csr_bus.data[SMAX_W-1:0];
            CSR_SENSOR_MAX_Y: sensor_max_y_ff <= csr_bus.data[SMAX_W-1:0];
            CSR_LEFT_EDGE:    left_edge_ff    <= $signed(csr_bus.data[LEFT_W-1:0]);
            CSR_RIGHT_EDGE:   right_edge_ff   <= csr_bus.data[RIGHT_W-1:0];
            CSR_TOP_EDGE:     top_edge_ff     <= $signed(csr_bus.data[TOP_W-1:0]);
            CSR_BOTTOM_EDGE:  bottom_edge_ff  <= csr_bus.data[BOTTOM_W-1:0];
            CSR_SHIFT_X:      shift_x_ff      <= $signed(csr_bus.data[SHIFT_W-1:0]);
            CSR_SHIFT_Y:      shift_y_ff      <= $signed(csr_bus.data[SHIFT_W-1:0]);
            default:          ;
         endcase
      end
   end

   always_comb begin
      cfg_x.smax  = sensor_max_x_ff;
      cfg_x.low   = LOW_W'(left_edge_ff);
      cfg_x.high  = HIGH_W'(right_edge_ff);
      cfg_x.shift = shift_x_ff;
      cfg_y.smax  = sensor_max_y_ff;
      cfg_y.low   = LOW_W'(top_edge_ff);
      cfg_y.high  = HIGH_W'(bottom_edge_ff);
      cfg_y.shift = shift_y_ff;
   end

   assign adv           = !vld_ff[LATENCY-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_bus.valid};
      end
   end

   tpcm_axis u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .raw     (req_bus.raw_x),
      .cfg     (cfg_x),
      .phys_m1 (PB_W'(PHYS_WIDTH - 1)),
      .tgt_max (OUT_W'(TARGET_WIDTH - 1)),
      .result  (res_x)
   );

   tpcm_axis u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .raw     (req_bus.raw_y),
      .cfg     (cfg_y),
      .phys_m1 (PB_W'(PHYS_HEIGHT - 1)),
      .tgt_max (OUT_W'(TARGET_HEIGHT - 1)),
      .result  (res_y)
   );

   assign rsp_bus.valid    = vld_ff[LATENCY-1];
   assign rsp_bus.screen_x = res_x[SX_W-1:0];
   assign rsp_bus.screen_y = res_y[SY_W-1:0];

endmodule

[hdl/tpcm_checker.sv]
module tpcm_checker import tpcm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [SX_W-1:0] screen_x,
   input logic [SY_W-1:0] screen_y
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(screen_x) && $stable(screen_y))
      else $error("result changed while stalled");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> screen_x <= SX_W'(SCREEN_X_MAX))
      else $error("screen_x above target");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> screen_y <= SY_W'(SCREEN_Y_MAX))
      else $error("screen_y above target");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("transfer taken while pipe is frozen");

   a_free_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind touch_point_calibration_map_core tpcm_checker u_tpcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .screen_x  (rsp_bus.screen_x),
   .screen_y  (rsp_bus.screen_y)
);

[tb/tpcm_checker.sv]
module tpcm_scoreboard import tpcm_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   tpcm_req_if   req_mon,
   tpcm_rsp_if   rsp_mon,
   tpcm_csr_if   csr_mon,
   output int    fail_count,
   output int    outstanding,
   output int    checked
);

   typedef struct packed {
      logic [SX_W-1:0] x;
      logic [SY_W-1:0] y;
   } screen_point_type;

   logic [SMAX_W-1:0]         smax_x;
   logic [SMAX_W-1:0]         smax_y;
   logic signed [LEFT_W-1:0]  left_edge;
   logic [RIGHT_W-1:0]        right_edge;
   logic signed [TOP_W-1:0]   top_edge;
   logic [BOTTOM_W-1:0]       bottom_edge;
   logic signed [SHIFT_W-1:0] shift_x;
   logic signed [SHIFT_W-1:0] shift_y;

   screen_point_type pending_points[$];
   screen_point_type oldest;
   int               sent_count;
   int               seen_count;

   assign outstanding = sent_count - seen_count;
   assign checked     = seen_count;

   function automatic longint calib_axis(input logic [RAW_W-1:0] raw,
                                         input logic [SMAX_W-1:0] smax,
                                         input logic signed [LOW_W-1:0] low,
                                         input logic [HIGH_W-1:0] high,
                                         input logic signed [SHIFT_W-1:0] shift,
                                         input longint phys,
                                         input longint target);
      longint v;
      longint mx;
      longint lo;
      longint hi;
      v  = raw;
      mx = smax;
      lo = low;
      hi = high;
      if (mx > 1 && mx != phys) begin
         v = (v * (phys - 1)) / (mx - 1);
      end
      if (hi > lo) begin
         v = ((v - lo) * (phys - 1)) / (hi - lo);
      end
      v = v + longint'(shift);
      if (v < 0) begin
         v = 0;
      end
      if (v >= target) begin
         v = target - 1;
      end
      return v;
   endfunction

   function automatic screen_point_type map_point(input logic [RAW_W-1:0] rx,
                                                  input logic [RAW_W-1:0] ry);
      longint           vx;
      longint           vy;
      screen_point_type p;
      vx  = calib_axis(rx, smax_x, left_edge, right_edge, shift_x,
                       PHYS_WIDTH, TARGET_WIDTH);
      vy  = calib_axis(ry, smax_y, top_edge, bottom_edge, shift_y,
                       PHYS_HEIGHT, TARGET_HEIGHT);
      p.x = vx[SX_W-1:0];
      p.y = vy[SY_W-1:0];
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         smax_x      = RST_SENSOR_MAX_X;
         smax_y      = RST_SENSOR_MAX_Y;
         left_edge   = RST_LEFT_EDGE;
         right_edge  = RST_RIGHT_EDGE;
         top_edge    = RST_TOP_EDGE;
         bottom_edge = RST_BOTTOM_EDGE;
         shift_x     = RST_SHIFT;
         shift_y     = RST_SHIFT;
         pending_points.delete();
         sent_count <= 0;
         seen_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SENSOR_MAX_X: smax_x      = csr_mon.data[SMAX_W-1:0];
               CSR_SENSOR_MAX_Y: smax_y      = csr_mon.data[SMAX_W-1:0];
               CSR_LEFT_EDGE:    left_edge   = csr_mon.data[LEFT_W-1:0];
               CSR_RIGHT_EDGE:   right_edge  = csr_mon.data[RIGHT_W-1:0];
               CSR_TOP_EDGE:     top_edge    = csr_mon.data[TOP_W-1:0];
               CSR_BOTTOM_EDGE:  bottom_edge = csr_mon.data[BOTTOM_W-1:0];
               CSR_SHIFT_X:      shift_x     = csr_mon.data[SHIFT_W-1:0];
               CSR_SHIFT_Y:      shift_y     = csr_mon.data[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_points.push_back(map_point(req_mon.raw_x, req_mon.raw_y));
            sent_count <= sent_count + 1;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_points.size() == 0) begin
               report_mismatch($sformatf("result (%0d,%0d) with no point pending",
                                         rsp_mon.screen_x, rsp_mon.screen_y));
            end else begin
               oldest = pending_points.pop_front();
               if (rsp_mon.screen_x !== oldest.x) begin
                  report_mismatch($sformatf("result %0d screen_x got %0d, want %0d",
                                            seen_count, rsp_mon.screen_x, oldest.x));
               end
               if (rsp_mon.screen_y !== oldest.y) begin
                  report_mismatch($sformatf("result %0d screen_y got %0d, want %0d",
                                            seen_count, rsp_mon.screen_y, oldest.y));
               end
            end
            seen_count <= seen_count + 1;
         end
      end
   end

endmodule

[tb/tb_top.sv]
module tb_top import tpcm_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int ITEMS_PER_SET  = 100;
   localparam int SETS_PER_PHASE = 6;

   logic clock = 1'b0;
   logic reset;

   int fail_count;
   int outstanding;
   int checked;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int stall_cycles;
   int config_loads;

   tpcm_req_if req_bus ();
   tpcm_rsp_if rsp_bus ();
   tpcm_csr_if csr_bus ();

   touch_point_calibration_map_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tpcm_scoreboard chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", stall_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random backpressure, plus long hold-offs on request
   initial begin : result_sink
      int hold_len;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_len     = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
         end
         rsp_bus.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
   end

   task automatic send_point(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_x <= x;
      req_bus.raw_y <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_config(input int sm_x, input int sm_y, input int left,
                             input int right, input int top, input int bottom,
                             input int sh_x, input int sh_y);
      logic [CSR_DATA_W-1:0] words [8];
      csr_index_type         idx;
      words[CSR_SENSOR_MAX_X] = sm_x[CSR_DATA_W-1:0];
      words[CSR_SENSOR_MAX_Y] = sm_y[CSR_DATA_W-1:0];
      words[CSR_LEFT_EDGE]    = left[CSR_DATA_W-1:0];
      words[CSR_RIGHT_EDGE]   = right[CSR_DATA_W-1:0];
      words[CSR_TOP_EDGE]     = top[CSR_DATA_W-1:0];
      words[CSR_BOTTOM_EDGE]  = bottom[CSR_DATA_W-1:0];
      words[CSR_SHIFT_X]      = sh_x[CSR_DATA_W-1:0];
      words[CSR_SHIFT_Y]      = sh_y[CSR_DATA_W-1:0];
      idx = idx.first();
      repeat (idx.num()) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data  <= words[idx];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         idx = idx.next();
      end
      csr_bus.valid <= 1'b0;
      config_loads++;
   endtask

   function automatic int pick_smax(input int phys);
      case ($urandom_range(9))
         0, 1, 2, 3: return phys / 2 + int'($urandom_range(phys));
         4:          return phys;
         5:          return int'($urandom_range(1));
         6:          return 2;
         7:          return (1 << SMAX_W) - 1;
         default:    return int'($urandom_range((1 << SMAX_W) - 1));
      endcase
   endfunction

   function automatic void pick_edges(input int phys, input int low_bits,
                                      input int high_bits, output int lo, output int hi);
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            lo = int'($urandom_range(100)) - 50;
            hi = phys - 50 + int'($urandom_range(100));
         end
         4, 5: begin
            lo = int'($urandom_range(2 * phys)) - phys;
            hi = int'($urandom_range(2 * phys));
         end
         6: begin
            hi = int'($urandom_range(phys));
            lo = hi;
         end
         7: begin
            hi = int'($urandom_range(phys / 2));
            lo = hi + 1 + int'($urandom_range(phys / 2 - 1));
         end
         default: begin
            lo = int'($urandom_range((1 << low_bits) - 1)) - (1 << (low_bits - 1));
            hi = int'($urandom_range((1 << high_bits) - 1));
         end
      endcase
   endfunction

   function automatic int pick_shift();
      if ($urandom_range(99) < 85) begin
         return int'($urandom_range(240)) - 120;
      end else begin
         return int'($urandom_range((1 << SHIFT_W) - 1)) - (1 << (SHIFT_W - 1));
      end
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw(input int smax, input int phys);
      int bound;
      int top_val;
      bound   = (smax > 1) ? smax : phys - 1;
      top_val = (1 << RAW_W) - 1;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return RAW_W'($urandom_range(bound));
         8: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return RAW_W'(bound);
               2:       return RAW_W'((bound < top_val) ? bound + 1 : top_val);
               default: return RAW_W'(top_val);
            endcase
         end
         default: return RAW_W'($urandom_range(top_val));
      endcase
   endfunction

   initial begin : stimulus
      int send_pcts [3];
      int recv_pcts [3];
      int sm_x;
      int sm_y;
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      send_pcts = '{27, 66, 0};
      recv_pcts = '{66, 27, 0};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 0;
      stall_cycles  = 0;
      config_loads  = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.raw_x <= '0;
      req_bus.raw_y <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_SENSOR_MAX_X;
      csr_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      send_point(12'd799, 12'd479);
      send_point(12'd800, 12'd480);
      send_point(12'd1, 12'd2);
      send_point(12'hAAA, 12'h555);
      drain_results();

      // rescale skipped (max 0 and 1), calibration skipped (equal / inverted edges)
      set_config(0, 1, 300, 300, 5, 2, 127, -128);
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      send_point(12'd700, 12'd3);
      drain_results();

      // smallest x rescale divisor (largest on y), widest edge span, full-width shifts
      set_config(2, 4095, -1024, 2047, -512, 1023, -128, 127);
      send_point(12'd0, 12'd0);
      send_point(12'd1, 12'd4095);
      send_point(12'd2, 12'd2048);
      send_point(12'd4095, 12'd1);
      drain_results();

      // max equals physical size, edges at minus and twice the physical size
      set_config(PHYS_WIDTH, PHYS_HEIGHT, -800, 1600, -480, 960, -120, 120);
      send_point(12'd0, 12'd0);
      send_point(12'd800, 12'd480);
      send_point(12'd4095, 12'd4095);
      drain_results();

      // raw beyond the sensor max, and raw at the top of its range
      set_config(640, 320, 100, 50, 20, 400, 120, -120);
      send_point(12'd1000, 12'd500);
      send_point(12'd639, 12'd319);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         for (int setting = 0; setting < SETS_PER_PHASE; setting++) begin
            sm_x = pick_smax(PHYS_WIDTH);
            sm_y = pick_smax(PHYS_HEIGHT);
            pick_edges(PHYS_WIDTH, LEFT_W, RIGHT_W, lo_x, hi_x);
            pick_edges(PHYS_HEIGHT, TOP_W, BOTTOM_W, lo_y, hi_y);
            set_config(sm_x, sm_y, lo_x, hi_x, lo_y, hi_y, pick_shift(), pick_shift());
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
               if (phase == 2 && setting == 1 && n == 20) begin
                  hold_request = HOLD_CYCLES;
               end
               send_point(pick_raw(sm_x, PHYS_WIDTH), pick_raw(sm_y, PHYS_HEIGHT));
            end
            drain_results();
         end
      end

      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d calibrated points across %0d register settings,",
               checked, config_loads);
      $display("three idle mixes and a %0d-cycle output hold-off.", HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
